// File: design/hough_line_vote_accumulator_macros.svh
// Assertion macros shared by the Hough line voting design.
`ifndef HOUGH_LINE_VOTE_ACCUMULATOR_MACROS_SVH
`define HOUGH_LINE_VOTE_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define HLVA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define HLVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define HLVA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HLVA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/hlva_pkg.sv
package hlva_pkg;

   localparam int NUM_ANGLES_DEF = 180;
   localparam int RHO_BINS_DEF   = 1024;
   localparam int MAX_WIDTH_DEF  = 640;
   localparam int MAX_HEIGHT_DEF = 480;

   // Signed centered pixel coordinates.
   localparam int DXW = 11;
   localparam int DYW = 10;

   localparam logic [1:0] OP_VOTE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_OFFSET = 2'd2;

   localparam logic [7:0]  PIXEL_EDGE = 8'hFF;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
   localparam logic [63:0] PI_Q30     = 64'd3373259426;

   typedef struct packed {
      logic valid;
      logic vote;
      logic read;
   } ctl_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] count;
   } res_type;

   // Restoring long division, used only while the sine constants are built.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, dv}) begin
            r    = r - {1'b0, dv};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // round(65536 * sin(deg)) in Q1.16, evaluated at elaboration only.
   function automatic logic signed [17:0] sin_q16(input int unsigned deg);
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  d;
      logic [17:0]  mag;
      int unsigned  dd;
      int unsigned  k;
      logic         neg;
      dd = deg;
      while (dd >= 360) begin
         dd = dd - 360;
      end
      neg = 1'b0;
      if (dd <= 90) begin
         k = dd;
      end else if (dd <= 180) begin
         k = 180 - dd;
      end else if (dd <= 270) begin
         k = dd - 180;
         neg = 1'b1;
      end else begin
         k = 360 - dd;
         neg = 1'b1;
      end
      x    = udiv64(64'(k) * PI_Q30 + 64'd90, 64'd180);
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = x;
      for (int i = 1; i <= 12; i++) begin
         d    = 64'((2 * i) * (2 * i + 1));
         term = (term * x2 + (64'd1 << 29)) >> 30;
         term = udiv64(term + (d >> 1), d);
         if ((i & 1) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      mag = 18'((sum + 64'd8192) >> 14);
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

// File: design/hough_line_vote_accumulator.sv
// A vote or read transaction travels the cell chain, one angle per cycle; a read
// result is registered from the end of the chain onto the response outputs.
// Input stalls until an accepted vote or read has left the chain, so the chain length sets the throughput.
// A clear transaction blocks input while every cell zeroes its memory.
// Reset (synchronous) restores the control and configuration registers and runs the same clearing pass.
module hough_line_vote_accumulator
   import hlva_pkg::*;
#(
   parameter int NUM_ANGLES = NUM_ANGLES_DEF,
   parameter int RHO_BINS   = RHO_BINS_DEF,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [9:0]  req_pixel_x,
   input  logic [8:0]  req_pixel_y,
   input  logic [7:0]  req_pixel_value,
   input  logic [7:0]  req_read_angle,
   input  logic [9:0]  req_read_rho_bin,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_bin_count,
   output logic        rsp_bin_saturated,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "hough_line_vote_accumulator_macros.svh"

   localparam int RBW = $clog2(RHO_BINS);
   localparam int CW  = $clog2(NUM_ANGLES + 3);

   logic [9:0]     width_ff;
   logic [8:0]     height_ff;
   logic [8:0]     offset_ff;
   logic [CW-1:0]  busy_ff;
   logic           clearing_ff;
   logic [RBW-1:0] clr_ff;
   res_type        seed_ff;
   logic           rsp_valid_ff;
   logic [15:0]    count_ff;
   logic           sat_ff;

   logic           accept;
   logic           vote_ok;
   logic           is_read;
   logic           cfg_wr;

   ctl_type               tok_w [NUM_ANGLES + 1];
   logic signed [DXW-1:0] dx_w  [NUM_ANGLES + 1];
   logic signed [DYW-1:0] dy_w  [NUM_ANGLES + 1];
   logic [8:0]            off_w [NUM_ANGLES + 1];
   logic [7:0]            ra_w  [NUM_ANGLES + 1];
   logic [9:0]            rr_w  [NUM_ANGLES + 1];
   res_type               res_w [NUM_ANGLES + 1];

   assign req_stall = clearing_ff || (busy_ff != '0) || (rsp_valid_ff && (req_op == OP_READ));
   assign accept    = req_valid && !req_stall;
   assign is_read   = req_op == OP_READ;
   assign vote_ok   = (req_op == OP_VOTE) && (req_pixel_value == PIXEL_EDGE)
                      && (req_pixel_x < width_ff) && (13'(req_pixel_x) < 13'(MAX_WIDTH))
                      && (req_pixel_y < height_ff) && (13'(req_pixel_y) < 13'(MAX_HEIGHT));
   assign cfg_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      case (paddr[3:2])
         REG_WIDTH:  prdata = 32'(width_ff);
         REG_HEIGHT: prdata = 32'(height_ff);
         REG_OFFSET: prdata = 32'(offset_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'd640;
         height_ff <= 9'd480;
         offset_ff <= 9'd400;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_WIDTH:  width_ff  <= pwdata[9:0];
            REG_HEIGHT: height_ff <= pwdata[8:0];
            REG_OFFSET: offset_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff.valid <= accept && is_read;
         seed_ff.count <= '0;
         if (accept && (req_op == OP_CLEAR)) begin
            clearing_ff <= 1'b1;
            clr_ff      <= '0;
         end else if (clearing_ff) begin
            if (clr_ff == RBW'(RHO_BINS - 1)) begin
               clearing_ff <= 1'b0;
            end
            clr_ff <= clr_ff + 1'b1;
         end
         if (accept && (vote_ok || is_read)) begin
            busy_ff <= CW'(NUM_ANGLES + 1);
         end else if (busy_ff != '0) begin
            busy_ff <= busy_ff - 1'b1;
         end
         if (res_w[NUM_ANGLES].valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_w[NUM_ANGLES].valid) begin
         count_ff <= res_w[NUM_ANGLES].count;
         sat_ff   <= res_w[NUM_ANGLES].count == COUNT_MAX;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_count     = count_ff;
   assign rsp_bin_saturated = sat_ff;

   always_comb begin
      tok_w[0].valid = accept && (vote_ok || is_read);
      tok_w[0].vote  = !is_read;
      tok_w[0].read  = is_read;
      dx_w[0]  = $signed({1'b0, req_pixel_x}) - $signed({2'b0, width_ff[9:1]});
      dy_w[0]  = $signed({1'b0, req_pixel_y}) - $signed({2'b0, height_ff[8:1]});
      off_w[0] = offset_ff;
      ra_w[0]  = req_read_angle;
      rr_w[0]  = req_read_rho_bin;
      res_w[0] = seed_ff;
   end

   for (genvar k = 0; k < NUM_ANGLES; k++) begin : g_cell
      hlva_cell #(
         .ANGLE    (k),
         .RHO_BINS (RHO_BINS),
         .RBW      (RBW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok_w[k]),
         .dx_in    (dx_w[k]),
         .dy_in    (dy_w[k]),
         .off_in   (off_w[k]),
         .ra_in    (ra_w[k]),
         .rr_in    (rr_w[k]),
         .res_in   (res_w[k]),
         .clr_en   (clearing_ff),
         .clr_addr (clr_ff),
         .tok_out  (tok_w[k + 1]),
         .dx_out   (dx_w[k + 1]),
         .dy_out   (dy_w[k + 1]),
         .off_out  (off_w[k + 1]),
         .ra_out   (ra_w[k + 1]),
         .rr_out   (rr_w[k + 1]),
         .res_out  (res_w[k + 1])
      );
   end

   `HLVA_ASSERT_IMPL(a_result_at_chain_end, clock, reset, res_w[NUM_ANGLES].valid, busy_ff == CW'(1))
   `HLVA_ASSERT_IMPL(a_no_accept_in_clear, clock, reset, clearing_ff, !accept)
   `HLVA_ASSERT_IMPL(a_no_overlap, clock, reset, busy_ff != '0, !accept && !clearing_ff)
   `HLVA_ASSERT_NEXT(a_read_seeds_chain, clock, reset, accept && is_read, seed_ff.valid)

endmodule

// File: design/hlva_cell.sv
module hlva_cell
   import hlva_pkg::*;
#(
   parameter int ANGLE    = 0,
   parameter int RHO_BINS = RHO_BINS_DEF,
   parameter int RBW      = $clog2(RHO_BINS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               tok_in,
   input  logic signed [DXW-1:0] dx_in,
   input  logic signed [DYW-1:0] dy_in,
   input  logic [8:0]            off_in,
   input  logic [7:0]            ra_in,
   input  logic [9:0]            rr_in,
   input  res_type               res_in,
   input  logic                  clr_en,
   input  logic [RBW-1:0]        clr_addr,
   output ctl_type               tok_out,
   output logic signed [DXW-1:0] dx_out,
   output logic signed [DYW-1:0] dy_out,
   output logic [8:0]            off_out,
   output logic [7:0]            ra_out,
   output logic [9:0]            rr_out,
   output res_type               res_out
);

   localparam int AW = 30;
   localparam logic signed [17:0] COS_C = sin_q16(ANGLE + 90);
   localparam logic signed [17:0] SIN_C = sin_q16(ANGLE);

   ctl_type               tok_ff;
   logic signed [DXW-1:0] dx_ff;
   logic signed [DYW-1:0] dy_ff;
   logic [8:0]            off_ff;
   logic [7:0]            ra_ff;
   logic [9:0]            rr_ff;
   res_type               res_ff;
   logic                  wr_ff;
   logic                  rdhit_ff;
   logic [RBW-1:0]        addr2_ff;
   logic [15:0]           q_ff;
   logic [15:0]           mem [RHO_BINS];

   logic signed [AW-1:0]  px;
   logic signed [AW-1:0]  py;
   logic signed [AW-1:0]  acc;
   logic signed [13:0]    rq;
   logic [15:0]           frac;
   logic                  inc;
   logic signed [15:0]    bin;
   logic                  bin_ok;
   logic                  vote_hit;
   logic                  read_hit;
   logic [RBW-1:0]        addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         res_ff   <= '0;
         wr_ff    <= 1'b0;
         rdhit_ff <= 1'b0;
      end else begin
         tok_ff   <= tok_in;
         res_ff   <= res_in;
         wr_ff    <= vote_hit;
         rdhit_ff <= read_hit;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      off_ff   <= off_in;
      ra_ff    <= ra_in;
      rr_ff    <= rr_in;
      addr2_ff <= addr;
   end

   always_comb begin
      px     = AW'(dx_ff) * AW'(COS_C);
      py     = AW'(dy_ff) * AW'(SIN_C);
      acc    = px + py;
      rq     = acc[AW-1:16];
      frac   = acc[15:0];
      inc    = (frac > 16'h8000) || ((frac == 16'h8000) && rq[0]);
      bin    = $signed({7'b0, off_ff}) + 16'(rq) + $signed({15'b0, inc});
      bin_ok = !bin[15] && (bin < 16'(RHO_BINS));
      vote_hit = tok_ff.valid && tok_ff.vote && bin_ok;
      read_hit = tok_ff.valid && tok_ff.read && (11'(ra_ff) == 11'(ANGLE))
                 && (13'(rr_ff) < 13'(RHO_BINS));
      addr = tok_ff.vote ? bin[RBW-1:0] : RBW'(rr_ff);
   end

   // The read issued while the token sits here returns next cycle, when the
   // incremented count is written back to the same bin.
   always_ff @(posedge clock) begin
      if (clr_en) begin
         mem[clr_addr] <= '0;
      end else if (wr_ff) begin
         mem[addr2_ff] <= (q_ff == COUNT_MAX) ? q_ff : q_ff + 16'd1;
      end
      q_ff <= mem[addr];
   end

   assign tok_out = tok_ff;
   assign dx_out  = dx_ff;
   assign dy_out  = dy_ff;
   assign off_out = off_ff;
   assign ra_out  = ra_ff;
   assign rr_out  = rr_ff;

   always_comb begin
      res_out = res_ff;
      if (rdhit_ff) begin
         res_out.count = q_ff;
      end
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import hlva_pkg::*;

   localparam int ANGLES = 180;
   localparam int BINS   = 1024;
   localparam int MAXW   = 640;
   localparam int MAXH   = 480;

   typedef struct {
      logic [1:0] op;
      logic [9:0] x;
      logic [8:0] y;
      logic [7:0] value;
      logic [7:0] angle;
      logic [9:0] rho;
   } hough_txn_type;

   typedef struct {
      logic [15:0] count;
      logic        sat;
   } bin_read_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_VOTE;
   logic [9:0]  req_pixel_x = '0;
   logic [8:0]  req_pixel_y = '0;
   logic [7:0]  req_pixel_value = '0;
   logic [7:0]  req_read_angle = '0;
   logic [9:0]  req_read_rho_bin = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_bin_count;
   logic        rsp_bin_saturated;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   hough_line_vote_accumulator dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   hough_txn_type pending_txns[$];
   bin_read_type  expected_reads[$];
   logic [15:0] vote_counts [0:ANGLES*BINS-1];
   longint      sine_tab [0:90];
   logic [9:0]  cfg_w = 10'd640;
   logic [8:0]  cfg_h = 9'd480;
   logic [8:0]  cfg_off = 9'd400;
   int          idle_mode = 0;
   int          rsp_hold = 0;
   int          errors = 0;
   bit          req_taken = 1'b0;
   int          last_x = 320;
   int          last_y = 240;

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic longint sin_of(int deg);
      int d;
      d = deg % 360;
      if (d <= 90) return sine_tab[d];
      if (d <= 180) return sine_tab[180 - d];
      if (d <= 270) return -sine_tab[d - 180];
      return -sine_tab[360 - d];
   endfunction

   // Rho bin of a pixel at one angle, rounded to nearest with ties to even.
   function automatic int rho_bin_of(int px, int py, int n);
      longint acc;
      longint r;
      acc = longint'(px - int'(cfg_w / 2)) * sin_of(n + 90)
          + longint'(py - int'(cfg_h / 2)) * sin_of(n);
      r = acc >>> 16;
      if (acc[15:0] > 16'h8000 || (acc[15:0] == 16'h8000 && r[0])) r++;
      return int'(cfg_off) + int'(r);
   endfunction

   // Input driver: a new transaction is offered only after the last one was taken.
   always @(negedge clock) begin
      hough_txn_type t;
      int idle_pct;
      idle_pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 77 : 0;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_txns.size() > 0 && $urandom_range(99) >= idle_pct) begin
            t = pending_txns.pop_front();
            req_op           <= t.op;
            req_pixel_x      <= t.x;
            req_pixel_y      <= t.y;
            req_pixel_value  <= t.value;
            req_read_angle   <= t.angle;
            req_read_rho_bin <= t.rho;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      int stall_pct;
      stall_pct = (idle_mode == 0) ? 77 : (idle_mode == 1) ? 22 : 0;
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Accepted transactions update the vote store copy; results are checked in order.
   always @(posedge clock) begin
      bin_read_type want;
      int b;
      int a;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         case (req_op)
            OP_VOTE: begin
               if (req_pixel_value == PIXEL_EDGE && req_pixel_x < cfg_w && req_pixel_x < MAXW
                   && req_pixel_y < cfg_h && req_pixel_y < MAXH) begin
                  for (int n = 0; n < ANGLES; n++) begin
                     b = rho_bin_of(int'(req_pixel_x), int'(req_pixel_y), n);
                     if (b >= 0 && b < BINS && vote_counts[n*BINS + b] != COUNT_MAX)
                        vote_counts[n*BINS + b]++;
                  end
               end
            end
            OP_READ: begin
               a = int'(req_read_angle);
               want.count = (a < ANGLES) ? vote_counts[a*BINS + int'(req_read_rho_bin)] : 16'd0;
               want.sat = (want.count == COUNT_MAX);
               expected_reads = {expected_reads, want};
            end
            OP_CLEAR: begin
               for (int i = 0; i < ANGLES*BINS; i++) vote_counts[i] = '0;
            end
            default: ;
         endcase
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reads.size() == 0) begin
            report_mismatch("unexpected result, count", int'(rsp_bin_count), -1);
         end else begin
            want = expected_reads.pop_front();
            if (rsp_bin_count !== want.count)
               report_mismatch("bin_count", int'(rsp_bin_count), int'(want.count));
            if (rsp_bin_saturated !== want.sat)
               report_mismatch("bin_saturated", int'(rsp_bin_saturated), int'(want.sat));
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 2'b00}; pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_WIDTH:  cfg_w = data[9:0];
         REG_HEIGHT: cfg_h = data[8:0];
         default:    cfg_off = data[8:0];
      endcase
   endtask

   // Waits until the block has drained, then lets the chain and any clear pass finish.
   task automatic wait_drained();
      while (pending_txns.size() > 0 || req_valid || expected_reads.size() > 0)
         @(posedge clock);
      repeat (BINS + ANGLES + 50) @(posedge clock);
   endtask

   task automatic set_config(int w, int h, int off);
      wait_drained();
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_OFFSET, off);
   endtask

   task automatic push_txn(logic [1:0] op, int x, int y, int v, int a, int r);
      hough_txn_type t;
      t.op = op; t.x = 10'(x); t.y = 9'(y); t.value = 8'(v); t.angle = 8'(a); t.rho = 10'(r);
      pending_txns = {pending_txns, t};
   endtask

   task automatic add_random(int count, int read_pct);
      int sel;
      int a;
      int b;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < read_pct) begin
            a = $urandom_range(ANGLES - 1);
            b = rho_bin_of(last_x, last_y, a);
            if ($urandom_range(9) < 6 && b >= 0 && b < BINS)
               push_txn(OP_READ, $urandom, $urandom, $urandom, a, b);
            else
               push_txn(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else if (sel < 97) begin
            if ($urandom_range(9) < 8) begin
               last_x = $urandom_range((cfg_w > 0) ? cfg_w : 1);
               last_y = $urandom_range((cfg_h > 0) ? cfg_h : 1);
               push_txn(OP_VOTE, last_x, last_y,
                        ($urandom_range(9) < 8) ? 255 : $urandom_range(255), 0, 0);
            end else begin
               push_txn(OP_VOTE, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
         end else if (sel < 99) begin
            push_txn(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            push_txn(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned d;
      // Sine in Q16 from an integer Taylor series evaluated in Q30.
      for (int k = 0; k <= 90; k++) begin
         x = (longint'(k) * longint'(PI_Q30) + 90) / 180;
         x2 = (x * x + (64'd1 << 29)) >> 30;
         term = x;
         sum = x;
         for (int i = 1; i <= 12; i++) begin
            d = 64'((2 * i) * (2 * i + 1));
            term = (term * x2 + (64'd1 << 29)) >> 30;
            term = (term + d / 2) / d;
            if (i % 2 == 1) sum -= term;
            else sum += term;
         end
         sine_tab[k] = (sum + 8192) >> 14;
      end
      for (int i = 0; i < ANGLES*BINS; i++) vote_counts[i] = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_config(640, 480, 400);
      idle_mode = 2;
      // Centre pixel lands on the offset bin at every angle.
      push_txn(OP_VOTE, 320, 240, 255, 0, 0);
      push_txn(OP_READ, 0, 0, 0, 0, 400);
      push_txn(OP_READ, 0, 0, 0, 90, 400);
      push_txn(OP_READ, 0, 0, 0, 179, 400);
      push_txn(OP_VOTE, 0, 0, 255, 0, 0);
      push_txn(OP_VOTE, 639, 479, 255, 0, 0);
      push_txn(OP_READ, 0, 0, 0, 0, 80);
      push_txn(OP_READ, 0, 0, 0, 0, 719);
      push_txn(OP_VOTE, 320, 240, 254, 0, 0);
      push_txn(OP_VOTE, 640, 240, 255, 0, 0);
      push_txn(OP_VOTE, 320, 480, 255, 0, 0);
      push_txn(OP_VOTE, 1023, 511, 255, 0, 0);
      push_txn(2'd3, 320, 240, 255, 0, 400);
      push_txn(OP_READ, 0, 0, 0, 180, 400);
      push_txn(OP_READ, 0, 0, 0, 255, 1023);
      push_txn(OP_READ, 0, 0, 0, 45, 1023);
      push_txn(OP_READ, 1023, 511, 255, 0, 400);
      push_txn(OP_CLEAR, 0, 0, 0, 0, 0);
      push_txn(OP_READ, 0, 0, 0, 0, 400);

      // Offset zero drops the votes with negative rho.
      set_config(640, 480, 0);
      push_txn(OP_VOTE, 0, 0, 255, 0, 0);
      push_txn(OP_READ, 0, 0, 0, 0, 0);
      push_txn(OP_READ, 0, 0, 0, 179, 320);
      idle_mode = 0;
      add_random(200, 30);

      set_config(1, 1, 511);
      idle_mode = 1;
      add_random(150, 30);

      set_config(17, 300, 255);
      idle_mode = 2;
      add_random(200, 30);

      // Long receiver hold-off while reads keep arriving, so the block backs up.
      set_config(640, 480, 400);
      idle_mode = 2;
      @(posedge clock);
      rsp_hold = 3000;
      add_random(40, 90);

      set_config(1023, 511, 511);
      idle_mode = 0;
      add_random(200, 30);

      set_config(0, 0, 100);
      idle_mode = 1;
      add_random(20, 30);

      set_config(640, 480, 400);
      idle_mode = 2;
      add_random(220, 30);

      while (pending_txns.size() > 0 || req_valid || expected_reads.size() > 0)
         @(posedge clock);
      repeat (ANGLES + 20) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(64'd12 * 64'd3000000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/hlva_pkg.sv
design/hlva_cell.sv
design/hough_line_vote_accumulator.sv
sim/tb_top.sv
